// ===== rtl/core/sdf_pkg.sv =====
package sdf_pkg;

    // Field widths fixed by the item format.
    localparam int VALUE_W = 64;
    localparam int LEN_W   = 2;
    localparam int PREC_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 32;
    localparam int DIGIT_W = 4;
    // Iteration counter holds the largest operand width, 64.
    localparam int ITER_W  = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [LEN_W-1:0] {
        LEN_INT   = 2'd0,
        LEN_LONG  = 2'd1,
        LEN_SHORT = 2'd2,
        LEN_CHAR  = 2'd3
    } length_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_SIGN,
        ST_PAD,
        ST_DIGITS
    } state_t;

    // Command from the sequencer to the shift-and-add-3 unit.
    typedef struct packed {
        logic               load;
        logic               step;
        logic [VALUE_W-1:0] mag;
    } dab_cmd_t;

    // Status returned by the shift-and-add-3 unit.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               overflow;
    } dab_stat_t;

endpackage

// ===== rtl/core/sdf_if.sv =====
interface sdf_in_if;
    import sdf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic [LEN_W-1:0]           length_mode;
    logic [PREC_W-1:0]          precision;
    logic                       space_flag;

    modport source (output valid, output value, output length_mode, output precision,
                    output space_flag, input ready);
    modport sink   (input valid, input value, input length_mode, input precision,
                    input space_flag, output ready);
endinterface

interface sdf_out_if;
    import sdf_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   out_char;
    logic                last;
    logic [COUNT_W-1:0]  total_count;

    modport source (output valid, output out_char, output last, output total_count,
                    input ready);
    modport sink   (input valid, input out_char, input last, input total_count,
                    output ready);
endinterface

// ===== rtl/core/sdf_dabble.sv =====
// Shift-and-add-3 binary to BCD unit. Each step adjusts every digit lane and
// shifts one magnitude bit in at the bottom.
module sdf_dabble #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdf_pkg::dab_cmd_t             cmd,
    input  logic [$clog2(MAX_DIGITS)-1:0] rd_idx,
    output sdf_pkg::dab_stat_t            stat
);
    import sdf_pkg::*;

    logic [VALUE_W-1:0] mag_reg;
    logic [DIGIT_W-1:0] bcd_reg [MAX_DIGITS];
    logic [DIGIT_W-1:0] adj     [MAX_DIGITS];
    logic               ovf_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= cmd.mag;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                bcd_reg[i] <= '0;
            end
        end
        else if (cmd.step)
        begin
            mag_reg    <= {mag_reg[VALUE_W-2:0], 1'b0};
            bcd_reg[0] <= {adj[0][DIGIT_W-2:0], mag_reg[VALUE_W-1]};
            for (int i = 1; i < MAX_DIGITS; i++)
            begin
                bcd_reg[i] <= {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
            end
        end
    end

    // A carry out of the top digit means the value has more digits than kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ovf_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            ovf_reg <= ovf_reg | adj[MAX_DIGITS-1][DIGIT_W-1];
        end
    end

    assign stat.digit    = bcd_reg[rd_idx];
    assign stat.overflow = ovf_reg;

endmodule

// ===== rtl/core/sdf_ctrl.sv =====
// Sequencer: takes an item, drives the conversion unit, finds the digit
// count, then emits sign, padding zeros and digits through an output register.
module sdf_ctrl #(
    parameter int MAX_PRECISION = 63,
    parameter int MAX_DIGITS    = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sdf_in_if.sink                        din,
    sdf_out_if.source                     dout,
    output sdf_pkg::dab_cmd_t             dab_cmd,
    output logic [$clog2(MAX_DIGITS)-1:0] rd_idx,
    input  sdf_pkg::dab_stat_t            dab_stat
);
    import sdf_pkg::*;

    localparam int IW = $clog2(MAX_DIGITS);
    localparam int PW = PREC_W + 1;

    state_t               state_reg, state_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [PREC_W-1:0]    prec_reg, prec_next;
    logic [PREC_W-1:0]    pad_reg, pad_next;
    logic                 neg_reg, neg_next;
    logic                 space_reg, space_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic [COUNT_W-1:0]   total_reg, total_next;

    logic                 accept;
    logic                 slot_free;
    logic                 scan_done;
    logic                 has_sign;
    logic [VALUE_W-1:0]   raw;
    logic [VALUE_W-1:0]   ext;
    logic [VALUE_W-1:0]   mag;
    logic [VALUE_W-1:0]   mag_aligned;
    logic [ITER_W-1:0]    width_bits;
    logic                 in_neg;
    logic [PREC_W-1:0]    prec_clamped;
    logic [PW-1:0]        ndig;
    logic [PW-1:0]        pad_calc;

    assign accept    = din.valid && din.ready;
    assign slot_free = !out_valid_reg || dout.ready;
    assign scan_done = dab_stat.overflow || (dab_stat.digit != '0) || (idx_reg == '0);
    assign has_sign  = neg_reg || space_reg;

    // Length cut with sign extension; the magnitude is aligned to the top so
    // the conversion only runs over the bits of the chosen width.
    always_comb
    begin
        raw = din.value;
        unique case (length_mode_t'(din.length_mode))
            LEN_INT:
            begin
                ext        = {{32{raw[31]}}, raw[31:0]};
                width_bits = ITER_W'(32);
            end
            LEN_LONG:
            begin
                ext        = raw;
                width_bits = ITER_W'(64);
            end
            LEN_SHORT:
            begin
                ext        = {{48{raw[15]}}, raw[15:0]};
                width_bits = ITER_W'(16);
            end
            LEN_CHAR:
            begin
                ext        = {{56{raw[7]}}, raw[7:0]};
                width_bits = ITER_W'(8);
            end
            default:
            begin
                ext        = raw;
                width_bits = ITER_W'(64);
            end
        endcase
        in_neg = ext[VALUE_W-1];
        mag    = in_neg ? (~ext + 64'd1) : ext;
        unique case (length_mode_t'(din.length_mode))
            LEN_INT:   mag_aligned = mag << 32;
            LEN_LONG:  mag_aligned = mag;
            LEN_SHORT: mag_aligned = mag << 48;
            LEN_CHAR:  mag_aligned = mag << 56;
            default:   mag_aligned = mag;
        endcase
        prec_clamped = (int'(din.precision) > MAX_PRECISION) ? PREC_W'(MAX_PRECISION)
                                                            : din.precision;
    end

    always_comb
    begin
        ndig     = PW'(idx_reg) + PW'(1);
        pad_calc = ({1'b0, prec_reg} > ndig) ? ({1'b0, prec_reg} - ndig) : '0;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    priority if (has_sign)
                        state_next = ST_SIGN;
                    else if (pad_calc != '0)
                        state_next = ST_PAD;
                    else
                        state_next = ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = (pad_reg != '0) ? ST_PAD : ST_DIGITS;
                end
            end
            ST_PAD:
            begin
                if (slot_free && pad_reg == PREC_W'(1))
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (slot_free && idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        iter_next      = iter_reg;
        idx_next       = idx_reg;
        prec_next      = prec_reg;
        pad_next       = pad_reg;
        neg_next       = neg_reg;
        space_next     = space_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        dab_cmd.load   = 1'b0;
        dab_cmd.step   = 1'b0;
        dab_cmd.mag    = mag_aligned;
        din.ready      = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dab_cmd.load = 1'b1;
                    iter_next    = width_bits;
                    prec_next    = prec_clamped;
                    neg_next     = in_neg;
                    space_next   = din.space_flag;
                end
            end
            ST_CONVERT:
            begin
                dab_cmd.step = 1'b1;
                iter_next    = iter_reg - ITER_W'(1);
                idx_next     = IW'(MAX_DIGITS - 1);
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    pad_next = PREC_W'(pad_calc);
                end
                else
                begin
                    idx_next = idx_reg - IW'(1);
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = neg_reg ? CHAR_MINUS : CHAR_SPACE;
                    last_next      = 1'b0;
                    total_next     = total_reg + COUNT_W'(1);
                end
            end
            ST_PAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO;
                    last_next      = 1'b0;
                    total_next     = total_reg + COUNT_W'(1);
                    pad_next       = pad_reg - PREC_W'(1);
                end
            end
            ST_DIGITS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + CHAR_W'(dab_stat.digit);
                    last_next      = (idx_reg == '0);
                    total_next     = total_reg + COUNT_W'(1);
                    if (idx_reg != '0)
                    begin
                        idx_next = idx_reg - IW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            iter_reg      <= '0;
            idx_reg       <= '0;
            pad_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            iter_reg      <= iter_next;
            idx_reg       <= idx_next;
            pad_reg       <= pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prec_reg  <= prec_next;
        neg_reg   <= neg_next;
        space_reg <= space_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign rd_idx           = idx_reg;
    assign dout.valid       = out_valid_reg;
    assign dout.out_char    = char_reg;
    assign dout.last        = last_reg;
    assign dout.total_count = total_reg;

endmodule

// ===== rtl/core/signed_decimal_formatter.sv =====
// Signed decimal formatter: each input item is one printf-style signed integer
// conversion (no field width). The argument is cut to 32, 64, 16 or 8 bits by
// length_mode and sign-extended; the block then sends one output item per ASCII
// character: '-' for a negative value or ' ' when space_flag is set (zero
// included), leading '0' characters up to the precision (clamped to
// MAX_PRECISION), then the decimal digits, with last set on the final one.
// Every output item also carries the wrapping 32-bit total of characters sent
// since reset. The conversion is a shift-and-add-3 unit that takes one
// magnitude bit per cycle over the W bits of the chosen width (W = 8, 16,
// 32 or 64 by length mode); the sequencer then scans down from the top digit
// to find the leading digit and sends the characters, one per cycle while the
// output side takes items, at most 64 characters. The input is ready only
// while the block is idle; the last character may still wait in the output
// register while the next item is accepted.
module signed_decimal_formatter #(
    parameter int MAX_PRECISION = 63,
    parameter int MAX_DIGITS    = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    sdf_in_if.sink    din,
    sdf_out_if.source dout
);
    import sdf_pkg::*;

    dab_cmd_t                      dab_cmd;
    dab_stat_t                     dab_stat;
    logic [$clog2(MAX_DIGITS)-1:0] rd_idx;

    // Sequencer with the output register and running character total.
    sdf_ctrl #(
        .MAX_PRECISION (MAX_PRECISION),
        .MAX_DIGITS    (MAX_DIGITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (din),
        .dout     (dout),
        .dab_cmd  (dab_cmd),
        .rd_idx   (rd_idx),
        .dab_stat (dab_stat)
    );

    // Binary to BCD unit holding the digits of the current item.
    sdf_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (dab_cmd),
        .rd_idx (rd_idx),
        .stat   (dab_stat)
    );

endmodule
